FILE: hdl/rc4_pkg.sv
// Shared widths, register indexes and controller/datapath command types for the RC4 core.
package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int PERM_DEPTH    = 256;
    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_IDX_W     = 4;
    localparam int KEY_LEN_W     = 5;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_KEY_LOW  = 2'd0;
    localparam t_cfg_idx CFG_KEY_HIGH = 2'd1;
    localparam t_cfg_idx CFG_KEY_LEN  = 2'd2;

    // Commands from the controller; several may be set in one cycle.
    typedef struct packed {
        logic load;       // capture the input byte
        logic sched_clr;  // clear schedule counter, key counter and j
        logic fill;       // write S[n] = n, advance n
        logic tail;       // write S[j] = held S value (second half of a swap)
        logic k_rd_n;     // read S[n]
        logic k_rd_j;     // take S[n], step j with key byte, read S[j]
        logic k_wr_n;     // write S[n] = S[j], advance n and key counter
        logic idx_clr;    // clear i and j
        logic g_rd_i;     // advance i, read S[i]
        logic g_rd_j;     // take S[i], step j, read S[j]
        logic g_wr_i;     // write S[i] = S[j], read S[S[i] + S[j]]
        logic g_out;      // load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic n_last;     // schedule counter at its last entry
    } t_dp_sts;

endpackage

FILE: hdl/rc4_in_if.sv
// Input channel: one data byte with its restart flag.
interface rc4_in_if import rc4_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

FILE: hdl/rc4_out_if.sv
// Output channel: one transformed byte.
interface rc4_out_if import rc4_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] result_byte;

    modport source (output valid, output result_byte, input ready);
    modport sink   (input valid, input result_byte, output ready);
endinterface

FILE: hdl/rc4_ctrl.sv
// Sequencer for key schedule and keystream generation.
module rc4_ctrl import rc4_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_restart,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_FILL = 10'b00_0000_0010,
        S_K1   = 10'b00_0000_0100,
        S_K2   = 10'b00_0000_1000,
        S_K3   = 10'b00_0001_0000,
        S_KFIN = 10'b00_0010_0000,
        S_G1   = 10'b00_0100_0000,
        S_G2   = 10'b00_1000_0000,
        S_G3   = 10'b01_0000_0000,
        S_G4   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_sched, n_sched;
    logic   r_tail, n_tail;
    logic   r_ovalid, n_ovalid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_sched  = r_sched;
        n_tail   = r_tail;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_restart || !r_sched) begin
                        o_cmd.sched_clr = 1'b1;
                        n_state         = S_FILL;
                    end else begin
                        n_state = S_G1;
                    end
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.n_last) begin
                    n_tail  = 1'b0;
                    n_state = S_K1;
                end
            end
            S_K1: begin
                // finish the previous swap while reading the next entry
                o_cmd.k_rd_n = 1'b1;
                o_cmd.tail   = r_tail;
                n_state      = S_K2;
            end
            S_K2: begin
                o_cmd.k_rd_j = 1'b1;
                n_state      = S_K3;
            end
            S_K3: begin
                o_cmd.k_wr_n = 1'b1;
                n_tail       = 1'b1;
                n_state      = i_sts.n_last ? S_KFIN : S_K1;
            end
            S_KFIN: begin
                o_cmd.tail    = 1'b1;
                o_cmd.idx_clr = 1'b1;
                n_sched       = 1'b1;
                n_state       = S_G1;
            end
            S_G1: begin
                o_cmd.g_rd_i = 1'b1;
                n_state      = S_G2;
            end
            S_G2: begin
                o_cmd.g_rd_j = 1'b1;
                n_state      = S_G3;
            end
            S_G3: begin
                o_cmd.g_wr_i = 1'b1;
                n_state      = S_G4;
            end
            S_G4: begin
                // hold until the result register is free
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.tail  = 1'b1;
                    o_cmd.g_out = 1'b1;
                    n_ovalid    = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sched  <= 1'b0;
            r_tail   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sched  <= n_sched;
            r_tail   <= n_tail;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

FILE: hdl/rc4_dpath.sv
// Permutation memory, indexes, key registers and result register.
module rc4_dpath import rc4_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [BYTE_W-1:0]     o_result_byte
);

    logic [BYTE_W-1:0]     r_perm [PERM_DEPTH];
    logic [BYTE_W-1:0]     r_rdata;

    logic [CFG_DATA_W-1:0] r_key_lo;
    logic [CFG_DATA_W-1:0] r_key_hi;
    logic [KEY_LEN_W-1:0]  r_key_len;

    logic [BYTE_W-1:0]     r_n;
    logic [KEY_IDX_W-1:0]  r_k;
    logic [BYTE_W-1:0]     r_i;
    logic [BYTE_W-1:0]     r_j;
    logic [BYTE_W-1:0]     r_sa;
    logic                  r_tj;
    logic [BYTE_W-1:0]     r_data;
    logic [BYTE_W-1:0]     r_out;

    logic                  mem_we;
    logic                  mem_re;
    logic [BYTE_W-1:0]     mem_waddr;
    logic [BYTE_W-1:0]     mem_wdata;
    logic [BYTE_W-1:0]     mem_raddr;

    logic [2*CFG_DATA_W-1:0] key_all;
    logic [BYTE_W-1:0]     key_b;
    logic [KEY_LEN_W-1:0]  key_len_eff;
    logic                  k_last;
    logic [BYTE_W-1:0]     j_ksa;
    logic [BYTE_W-1:0]     j_prga;
    logic [BYTE_W-1:0]     i_inc;
    logic [BYTE_W-1:0]     t_idx;

    assign key_all = {r_key_hi, r_key_lo};
    assign key_b   = key_all[r_k*BYTE_W +: BYTE_W];

    // zero length acts as one byte, long lengths saturate
    always_comb begin
        if (r_key_len == '0) begin
            key_len_eff = KEY_LEN_W'(1);
        end else if (r_key_len > KEY_LEN_W'(MAX_KEY_BYTES)) begin
            key_len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
        end else begin
            key_len_eff = r_key_len;
        end
    end

    assign k_last       = ({1'b0, r_k} == (key_len_eff - KEY_LEN_W'(1)));
    assign j_ksa        = r_j + r_rdata + key_b;
    assign j_prga       = r_j + r_rdata;
    assign i_inc        = r_i + BYTE_W'(1);
    assign t_idx        = r_sa + r_rdata;
    assign o_sts.n_last = (r_n == {BYTE_W{1'b1}});
    assign o_result_byte = r_out;

    // hold the read data while no read is issued, so a stalled last step keeps it
    assign mem_re = i_cmd.k_rd_n | i_cmd.k_rd_j | i_cmd.g_rd_i | i_cmd.g_rd_j | i_cmd.g_wr_i;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_j;
        mem_wdata = r_sa;
        mem_raddr = r_n;
        if (i_cmd.fill) begin
            mem_we    = 1'b1;
            mem_waddr = r_n;
            mem_wdata = r_n;
        end
        if (i_cmd.tail) begin
            mem_we    = 1'b1;
            mem_waddr = r_j;
            mem_wdata = r_sa;
        end
        if (i_cmd.k_rd_j) begin
            mem_raddr = j_ksa;
        end
        if (i_cmd.k_wr_n) begin
            mem_we    = 1'b1;
            mem_waddr = r_n;
            mem_wdata = r_rdata;
        end
        if (i_cmd.g_rd_i) begin
            mem_raddr = i_inc;
        end
        if (i_cmd.g_rd_j) begin
            mem_raddr = j_prga;
        end
        if (i_cmd.g_wr_i) begin
            mem_we    = 1'b1;
            mem_waddr = r_i;
            mem_wdata = r_rdata;
            mem_raddr = t_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_perm[mem_waddr] <= mem_wdata;
        end
    end

    // a read at the address being written returns the new value
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            if (mem_we && (mem_waddr == mem_raddr)) begin
                r_rdata <= mem_wdata;
            end else begin
                r_rdata <= r_perm[mem_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo  <= '0;
            r_key_hi  <= '0;
            r_key_len <= KEY_LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_LOW:  r_key_lo  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_hi  <= i_cfg_data;
                CFG_KEY_LEN:  r_key_len <= i_cfg_data[KEY_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
            r_k <= '0;
            r_i <= '0;
            r_j <= '0;
        end else begin
            if (i_cmd.sched_clr) begin
                r_n <= '0;
                r_k <= '0;
                r_j <= '0;
            end
            if (i_cmd.fill) begin
                r_n <= r_n + BYTE_W'(1);
            end
            if (i_cmd.k_rd_j) begin
                r_j <= j_ksa;
            end
            if (i_cmd.k_wr_n) begin
                r_n <= r_n + BYTE_W'(1);
                r_k <= k_last ? '0 : r_k + KEY_IDX_W'(1);
            end
            if (i_cmd.idx_clr) begin
                r_i <= '0;
                r_j <= '0;
            end
            if (i_cmd.g_rd_i) begin
                r_i <= i_inc;
            end
            if (i_cmd.g_rd_j) begin
                r_j <= j_prga;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_data <= i_data_byte;
        end
        if (i_cmd.k_rd_j || i_cmd.g_rd_j) begin
            r_sa <= r_rdata;
        end
        if (i_cmd.g_wr_i) begin
            // the output index may hit S[j], whose swap is written only in the final step
            r_tj <= (t_idx == r_j);
        end
        if (i_cmd.g_out) begin
            r_out <= (r_tj ? r_sa : r_rdata) ^ r_data;
        end
    end

endmodule

FILE: hdl/rc4_stream_cipher_core.sv
// Top level of the byte-serial RC4 core.
//
//  channel        dir  handshake     payload
//  i_data_chan    in   valid/ready   data_byte[7:0], restart
//  o_result_chan  out  valid/ready   result_byte[7:0]
//  i_cfg_*        in   write enable  index[1:0], data[63:0]
//
// A byte without key schedule goes from transfer to result through an accept
// step and four steps on the one-read, one-write permutation memory
// (read S[i], read S[j], write S[i] with output read, write S[j]).
// A restart, or the first byte after reset, fills the permutation, runs the
// key schedule (read S[n], read S[j], write S[n]) and closes the last swap.
// Reset clears indexes and the key-scheduled flag, not the memory.
// The finished byte sits in an output register; on a stall the core holds in
// its last step until that register is free, and takes no new byte meanwhile.
module rc4_stream_cipher_core import rc4_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rc4_in_if.sink                i_data_chan,
    rc4_out_if.source             o_result_chan,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rc4_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_data_chan.valid),
        .i_in_restart (i_data_chan.restart),
        .o_in_ready   (i_data_chan.ready),
        .o_out_valid  (o_result_chan.valid),
        .i_out_ready  (o_result_chan.ready),
        .o_cmd        (dp_cmd),
        .i_sts        (dp_sts)
    );

    rc4_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_data_byte   (i_data_chan.data_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_result_byte (o_result_chan.result_byte)
    );

endmodule
